/* design/debug_access_dispatch_with_call_trace_core_macros.svh */
// assertion macros for the debug access dispatch core
// no dependencies; included by the top level
`ifndef DEBUG_ACCESS_DISPATCH_WITH_CALL_TRACE_CORE_MACROS_SVH
`define DEBUG_ACCESS_DISPATCH_WITH_CALL_TRACE_CORE_MACROS_SVH

// same-cycle implication
`define DAD_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DAD_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/dad_pkg.sv */
// shared types and codes of the debug access dispatch core
// no dependencies
package dad_pkg;

	// input mode codes
	localparam logic [1:0] MODE_CALL = 2'd0;
	localparam logic [1:0] MODE_RET  = 2'd1;
	localparam logic [1:0] MODE_REQ  = 2'd2;
	localparam logic [1:0] MODE_DONE = 2'd3;

	// request kinds
	localparam logic [1:0] REQ_REGACC = 2'd0;
	localparam logic [1:0] REQ_PROG   = 2'd1;

	// address regions and indexes
	localparam logic [3:0]  REGION_CSR   = 4'h0;
	localparam logic [3:0]  REGION_REG   = 4'h1;
	localparam logic [3:0]  REGION_DBG   = 4'hC;
	localparam logic [11:0] IDX_COUNT    = 12'd64;
	localparam logic [11:0] IDX_TRACE    = 12'd128;

	// result kinds
	localparam logic [1:0] RES_RESP = 2'd0;
	localparam logic [1:0] RES_CSR  = 2'd1;
	localparam logic [1:0] RES_REG  = 2'd2;
	localparam logic [1:0] RES_PROG = 2'd3;

	// queue between front and back
	localparam int QUEUE_DEPTH_LOG2 = 1;

	typedef enum logic [3:0] {
		OP_CALL,
		OP_RET,
		OP_DONE,
		OP_PROG,
		OP_UNSUP,
		OP_CSR,
		OP_REG,
		OP_CNT,
		OP_ENTRY,
		OP_ZERO
	} op_kind_t;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_CSR  = 2'd1,
		PEND_REG  = 2'd2,
		PEND_PROG = 2'd3
	} pending_t;

	// classified item; addr holds the csr number, register index or trace offset
	typedef struct packed {
		op_kind_t    kind;
		logic        wr;
		logic [11:0] addr;
		logic [63:0] data;
		logic        terr;
	} op_t;

	typedef struct packed {
		pending_t pending;
		logic     out_fwd;
	} back_status_t;

endpackage

/* design/debug_access_dispatch_with_call_trace_core.sv */
// top level of the debug access dispatch core with call trace store
// depends on dad_pkg, dad_front, dad_queue, dad_back and the macros header
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | mode req_kind is_write req_addr data_in
//          |                       | call_pc call_next_pc target_error
//  out     | out_valid / out_ready | result_kind fwd_write fwd_addr data_out
//          |                       | rsp_err
//
// one request per cycle unless the output stalls; a result passes the front register,
// the queue and the back result register, the trace read port sets the last stage
// reset clears the trace count, the pending target, the queue and both stage valids
// the user reads trace entries only after a call writes them; the core does not enforce it
// a stalled output holds the back, the two-entry queue lets the front take requests till full
`include "debug_access_dispatch_with_call_trace_core_macros.svh"

module debug_access_dispatch_with_call_trace_core #(
	parameter int TRACE_DEPTH_LOG2 = 5,
	parameter int PC_BITS          = 39
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [1:0]         req_kind,
	input  logic               is_write,
	input  logic [15:0]        req_addr,
	input  logic [63:0]        data_in,
	input  logic [PC_BITS-1:0] call_pc,
	input  logic [PC_BITS-1:0] call_next_pc,
	input  logic               target_error,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic               fwd_write,
	output logic [11:0]        fwd_addr,
	output logic [63:0]        data_out,
	output logic               rsp_err
);
	import dad_pkg::*;

	localparam int QW = $bits(op_t) + 2 * PC_BITS;

	logic               f_valid;
	logic               f_ready;
	op_t                f_op;
	logic [PC_BITS-1:0] f_pc;
	logic [PC_BITS-1:0] f_next_pc;
	logic               b_valid;
	logic               b_pop;
	op_t                b_op;
	logic [PC_BITS-1:0] b_pc;
	logic [PC_BITS-1:0] b_next_pc;
	back_status_t       bstat;

	dad_front #(
		.TRACE_DEPTH_LOG2(TRACE_DEPTH_LOG2),
		.PC_BITS(PC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.req_kind(req_kind),
		.is_write(is_write),
		.req_addr(req_addr),
		.data_in(data_in),
		.call_pc(call_pc),
		.call_next_pc(call_next_pc),
		.target_error(target_error),
		.q_valid(f_valid),
		.q_ready(f_ready),
		.q_op(f_op),
		.q_pc(f_pc),
		.q_next_pc(f_next_pc)
	);

	dad_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data({f_op, f_pc, f_next_pc}),
		.pop_valid(b_valid),
		.pop_ready(b_pop),
		.pop_data({b_op, b_pc, b_next_pc})
	);

	dad_back #(
		.TRACE_DEPTH_LOG2(TRACE_DEPTH_LOG2),
		.PC_BITS(PC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(b_valid),
		.q_pop(b_pop),
		.op(b_op),
		.op_pc(b_pc),
		.op_next_pc(b_next_pc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.fwd_write(fwd_write),
		.fwd_addr(fwd_addr),
		.data_out(data_out),
		.rsp_err(rsp_err),
		.status(bstat)
	);

	// a taken request is always staged toward the queue
	`DAD_ASSERT_NXT(a_accept_staged, clk, arst_n, in_valid && in_ready, f_valid, "request lost in front")
	// a forwarded request on the output means its target is still pending
	`DAD_ASSERT_IMP(a_fwd_pending, clk, arst_n, bstat.out_fwd, bstat.pending != PEND_NONE, "fwd without pending")
	// forwarded requests never carry an error
	`DAD_ASSERT_IMP(a_fwd_no_err, clk, arst_n, out_valid && result_kind != RES_RESP, !rsp_err, "fwd with error")

endmodule

/* design/dad_queue.sv */
// short fifo between the classify front and the execute back
// depends on dad_pkg for the queue depth
module dad_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	import dad_pkg::*;

	localparam int DEPTH = 1 << QUEUE_DEPTH_LOG2;

	logic [W-1:0]                store_q [DEPTH];
	logic [QUEUE_DEPTH_LOG2-1:0] wr_ptr_q;
	logic [QUEUE_DEPTH_LOG2-1:0] rd_ptr_q;
	logic [QUEUE_DEPTH_LOG2:0]   cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (cnt_q != (QUEUE_DEPTH_LOG2+1)'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			store_q[wr_ptr_q] <= push_data;
	end

endmodule

/* design/dad_front.sv */
// input stage: takes items and decodes them into operation kinds
// depends on dad_pkg
module dad_front #(
	parameter int TRACE_DEPTH_LOG2 = 5,
	parameter int PC_BITS          = 39
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [1:0]          req_kind,
	input  logic                is_write,
	input  logic [15:0]         req_addr,
	input  logic [63:0]         data_in,
	input  logic [PC_BITS-1:0]  call_pc,
	input  logic [PC_BITS-1:0]  call_next_pc,
	input  logic                target_error,
	output logic                q_valid,
	input  logic                q_ready,
	output dad_pkg::op_t        q_op,
	output logic [PC_BITS-1:0]  q_pc,
	output logic [PC_BITS-1:0]  q_next_pc
);
	import dad_pkg::*;

	localparam logic [12:0] TRACE_SPAN = 13'(2 << TRACE_DEPTH_LOG2);

	logic               v_s1;
	op_t                op_s1;
	logic [PC_BITS-1:0] pc_s1;
	logic [PC_BITS-1:0] next_s1;
	op_t                op_d;
	logic [3:0]         region;
	logic [11:0]        idx;
	logic [11:0]        idx_off;
	logic               in_trace;

	assign in_ready  = !v_s1 || q_ready;
	assign q_valid   = v_s1;
	assign q_op      = op_s1;
	assign q_pc      = pc_s1;
	assign q_next_pc = next_s1;

	assign region   = req_addr[15:12];
	assign idx      = req_addr[11:0];
	assign idx_off  = idx - IDX_TRACE;
	assign in_trace = (idx >= IDX_TRACE) && ({1'b0, idx_off} < TRACE_SPAN);

	always_comb begin
		op_d      = '0;
		op_d.wr   = is_write;
		op_d.addr = idx;
		op_d.data = data_in;
		op_d.terr = target_error;
		op_d.kind = OP_ZERO;
		unique case (mode)
			MODE_CALL: op_d.kind = OP_CALL;
			MODE_RET:  op_d.kind = OP_RET;
			MODE_DONE: op_d.kind = OP_DONE;
			MODE_REQ: begin
				unique case (req_kind)
					REQ_PROG: op_d.kind = OP_PROG;
					REQ_REGACC: begin
						unique case (region)
							REGION_CSR: op_d.kind = OP_CSR;
							REGION_REG: begin
								op_d.kind = OP_REG;
								op_d.addr = {6'd0, req_addr[5:0]};
							end
							REGION_DBG: begin
								if (idx == IDX_COUNT) begin
									op_d.kind = OP_CNT;
								end else if (in_trace) begin
									op_d.kind = OP_ENTRY;
									op_d.addr = idx_off;
								end else begin
									op_d.kind = OP_ZERO;
								end
							end
							default: op_d.kind = OP_ZERO;
						endcase
					end
					default: op_d.kind = OP_UNSUP;
				endcase
			end
			default: op_d.kind = OP_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (q_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op_d;
			pc_s1   <= call_pc;
			next_s1 <= call_next_pc;
		end
	end

endmodule

/* design/dad_back.sv */
// execute stage: trace store, pending target tracking and the result register
// depends on dad_pkg
module dad_back #(
	parameter int TRACE_DEPTH_LOG2 = 5,
	parameter int PC_BITS          = 39
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  dad_pkg::op_t          op,
	input  logic [PC_BITS-1:0]    op_pc,
	input  logic [PC_BITS-1:0]    op_next_pc,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            result_kind,
	output logic                  fwd_write,
	output logic [11:0]           fwd_addr,
	output logic [63:0]           data_out,
	output logic                  rsp_err,
	output dad_pkg::back_status_t status
);
	import dad_pkg::*;

	localparam int DEPTH = 1 << TRACE_DEPTH_LOG2;

	logic [PC_BITS-1:0]          pc_mem   [DEPTH];
	logic [PC_BITS-1:0]          next_mem [DEPTH];
	logic [PC_BITS-1:0]          rd_q;
	logic [TRACE_DEPTH_LOG2-1:0] count_q;
	pending_t                    pend_q;

	logic        v_s1;
	logic [1:0]  kind_s1;
	logic        wr_s1;
	logic [11:0] addr_s1;
	logic [63:0] data_s1;
	logic        err_s1;
	logic        mem_s1;

	logic                        has_res;
	logic [1:0]                  kind_d;
	logic                        wr_d;
	logic [11:0]                 addr_d;
	logic [63:0]                 data_d;
	logic                        err_d;
	logic                        use_mem;
	logic                        mem_we;
	logic [TRACE_DEPTH_LOG2-1:0] cnt_d;
	pending_t                    pend_d;
	logic                        idle;
	logic [TRACE_DEPTH_LOG2-1:0] slot;

	assign q_pop = q_valid && (!v_s1 || out_ready);
	assign idle  = (pend_q == PEND_NONE);
	assign slot  = op.addr[TRACE_DEPTH_LOG2:1];

	always_comb begin
		has_res = 1'b0;
		kind_d  = RES_RESP;
		wr_d    = 1'b0;
		addr_d  = '0;
		data_d  = '0;
		err_d   = 1'b0;
		use_mem = 1'b0;
		mem_we  = 1'b0;
		cnt_d   = count_q;
		pend_d  = pend_q;
		unique case (op.kind)
			OP_CALL: begin
				if (count_q != '1) begin
					mem_we = 1'b1;
					cnt_d  = count_q + 1'b1;
				end
			end
			OP_RET: begin
				if (count_q != '0)
					cnt_d = count_q - 1'b1;
			end
			OP_DONE: begin
				if (!idle) begin
					has_res = 1'b1;
					data_d  = op.data;
					err_d   = (pend_q == PEND_PROG) && op.terr;
					pend_d  = PEND_NONE;
				end
			end
			OP_PROG: begin
				if (idle) begin
					has_res = 1'b1;
					kind_d  = RES_PROG;
					pend_d  = PEND_PROG;
				end
			end
			OP_UNSUP: begin
				if (idle) begin
					has_res = 1'b1;
					err_d   = 1'b1;
				end
			end
			OP_CSR: begin
				if (idle) begin
					has_res = 1'b1;
					kind_d  = RES_CSR;
					wr_d    = op.wr;
					addr_d  = op.addr;
					data_d  = op.data;
					pend_d  = PEND_CSR;
				end
			end
			OP_REG: begin
				if (idle) begin
					has_res = 1'b1;
					kind_d  = RES_REG;
					wr_d    = op.wr;
					addr_d  = op.addr;
					data_d  = op.wr ? op.data : '0;
					pend_d  = PEND_REG;
				end
			end
			OP_CNT: begin
				if (idle) begin
					has_res = 1'b1;
					data_d  = 64'(count_q);
					if (op.wr)
						cnt_d = op.data[TRACE_DEPTH_LOG2-1:0];
				end
			end
			OP_ENTRY: begin
				if (idle) begin
					has_res = 1'b1;
					use_mem = 1'b1;
				end
			end
			OP_ZERO: begin
				if (idle)
					has_res = 1'b1;
			end
			default: has_res = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= PEND_NONE;
			v_s1    <= 1'b0;
		end else begin
			if (q_pop) begin
				count_q <= cnt_d;
				pend_q  <= pend_d;
				v_s1    <= has_res;
			end else if (out_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_res) begin
			kind_s1 <= kind_d;
			wr_s1   <= wr_d;
			addr_s1 <= addr_d;
			data_s1 <= data_d;
			err_s1  <= err_d;
			mem_s1  <= use_mem;
		end
	end

	// trace store, one write port at the count, one registered read port
	always_ff @(posedge clk) begin
		if (q_pop && mem_we) begin
			pc_mem[count_q]   <= op_pc;
			next_mem[count_q] <= op_next_pc;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && use_mem)
			rd_q <= op.addr[0] ? next_mem[slot] : pc_mem[slot];
	end

	assign out_valid   = v_s1;
	assign result_kind = kind_s1;
	assign fwd_write   = wr_s1;
	assign fwd_addr    = addr_s1;
	assign data_out    = mem_s1 ? 64'(rd_q) : data_s1;
	assign rsp_err     = err_s1;

	assign status.pending = pend_q;
	assign status.out_fwd = v_s1 && (kind_s1 != RES_RESP);

endmodule

/* test/debug_access_dispatch_with_call_trace_core_test.sv */
// self-checking testbench for debug_access_dispatch_with_call_trace_core
// depends on dad_pkg and the rtl of the core; a scoreboard class predicts every result
// directed requests first, then random call/return traffic mixed with debug requests
module debug_access_dispatch_with_call_trace_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dad_pkg::*;

	localparam int CNT_W = 5;
	localparam int PC_W = 39;
	localparam int SLOTS = 1 << CNT_W;
	localparam int ITEM_GOAL = 950;
	localparam int LONG_HOLD = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam int MAX_REPORTS = 60;

	// request kinds with no decode in the core
	localparam logic [1:0] REQ_RSVD_2 = 2'd2;
	localparam logic [1:0] REQ_RSVD_3 = 2'd3;
	localparam logic [15:0] ADDR_COUNT = {REGION_DBG, IDX_COUNT};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic [1:0] req_kind;
	logic is_write;
	logic [15:0] req_addr;
	logic [63:0] data_in;
	logic [PC_W-1:0] call_pc;
	logic [PC_W-1:0] call_next_pc;
	logic target_error;
	logic out_valid;
	logic out_ready;
	logic [1:0] result_kind;
	logic fwd_write;
	logic [11:0] fwd_addr;
	logic [63:0] data_out;
	logic rsp_err;

	bit hold_req;
	bit hold_active;
	int quiet_cycles;

	debug_access_dispatch_with_call_trace_core #(
		.TRACE_DEPTH_LOG2(CNT_W),
		.PC_BITS(PC_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.req_kind(req_kind),
		.is_write(is_write),
		.req_addr(req_addr),
		.data_in(data_in),
		.call_pc(call_pc),
		.call_next_pc(call_next_pc),
		.target_error(target_error),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.fwd_write(fwd_write),
		.fwd_addr(fwd_addr),
		.data_out(data_out),
		.rsp_err(rsp_err)
	);

	typedef struct {
		logic [1:0] mode;
		logic [1:0] kind;
		logic wr;
		logic [15:0] addr;
		logic [63:0] data;
		logic [PC_W-1:0] pc;
		logic [PC_W-1:0] npc;
		logic terr;
	} dbg_item_t;

	typedef struct {
		logic [1:0] kind;
		logic wr;
		logic [11:0] addr;
		logic [63:0] data;
		logic err;
	} result_item_t;

	class dispatch_scoreboard;
		logic [PC_W-1:0] frame_pc [SLOTS];
		logic [PC_W-1:0] frame_next [SLOTS];
		bit frame_written [SLOTS];
		logic [CNT_W-1:0] frame_count;
		pending_t waiting_on;
		result_item_t due_results [$];
		int mismatches;

		function new();
			frame_count = '0;
			waiting_on = PEND_NONE;
			mismatches = 0;
			foreach (frame_written[i]) frame_written[i] = 1'b0;
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		function void queue_result(logic [1:0] k, logic w, logic [11:0] a, logic [63:0] d,
				logic e);
			result_item_t r;
			r.kind = k;
			r.wr = w;
			r.addr = a;
			r.data = d;
			r.err = e;
			due_results.push_back(r);
		endfunction

		function void note_request(dbg_item_t it);
			logic [11:0] idx;
			logic [CNT_W-1:0] slot;
			logic [CNT_W-1:0] old_count;
			logic [PC_W-1:0] val;
			idx = it.addr[11:0];
			case (it.mode)
				MODE_CALL: begin
					// one slot always stays free
					if (frame_count != '1) begin
						frame_pc[frame_count] = it.pc;
						frame_next[frame_count] = it.npc;
						frame_written[frame_count] = 1'b1;
						frame_count = frame_count + 1'b1;
					end
				end
				MODE_RET: begin
					if (frame_count != '0) frame_count = frame_count - 1'b1;
				end
				MODE_DONE: begin
					if (waiting_on != PEND_NONE) begin
						queue_result(RES_RESP, 1'b0, '0, it.data,
							(waiting_on == PEND_PROG) ? it.terr : 1'b0);
						waiting_on = PEND_NONE;
					end
				end
				default: begin
					if (waiting_on != PEND_NONE) return;
					case (it.kind)
						REQ_PROG: begin
							waiting_on = PEND_PROG;
							queue_result(RES_PROG, 1'b0, '0, '0, 1'b0);
						end
						REQ_REGACC: begin
							case (it.addr[15:12])
								REGION_CSR: begin
									waiting_on = PEND_CSR;
									queue_result(RES_CSR, it.wr, idx, it.data, 1'b0);
								end
								REGION_REG: begin
									waiting_on = PEND_REG;
									queue_result(RES_REG, it.wr, {6'd0, it.addr[5:0]},
										it.wr ? it.data : 64'd0, 1'b0);
								end
								REGION_DBG: begin
									if (idx == IDX_COUNT) begin
										old_count = frame_count;
										if (it.wr) frame_count = it.data[CNT_W-1:0];
										queue_result(RES_RESP, 1'b0, '0, 64'(old_count), 1'b0);
									end else if (idx >= IDX_TRACE &&
											idx < IDX_TRACE + 12'(2 * SLOTS)) begin
										// writes here are dropped but still answered
										slot = CNT_W'((idx - IDX_TRACE) >> 1);
										val = idx[0] ? frame_next[slot] : frame_pc[slot];
										queue_result(RES_RESP, 1'b0, '0, 64'(val), 1'b0);
									end else begin
										queue_result(RES_RESP, 1'b0, '0, '0, 1'b0);
									end
								end
								default: begin
									queue_result(RES_RESP, 1'b0, '0, '0, 1'b0);
								end
							endcase
						end
						default: begin
							queue_result(RES_RESP, 1'b0, '0, '0, 1'b1);
						end
					endcase
				end
			endcase
		endfunction

		function void report_field(string field, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		endfunction

		function void check_result(result_item_t got);
			result_item_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none expected, actual kind %0d data %h",
						$time, got.kind, got.data);
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind) report_field("result_kind", 64'(want.kind), 64'(got.kind));
			if (got.wr !== want.wr) report_field("fwd_write", 64'(want.wr), 64'(got.wr));
			if (got.addr !== want.addr) report_field("fwd_addr", 64'(want.addr), 64'(got.addr));
			if (got.data !== want.data) report_field("data_out", want.data, got.data);
			if (got.err !== want.err) report_field("rsp_err", 64'(want.err), 64'(got.err));
		endfunction
	endclass

	dispatch_scoreboard sb = new();

	function automatic dbg_item_t random_item(logic [1:0] md);
		dbg_item_t it;
		it.mode = md;
		it.kind = 2'($urandom);
		it.wr = 1'($urandom);
		it.addr = 16'($urandom);
		it.data = {$urandom, $urandom};
		it.pc = PC_W'({$urandom, $urandom});
		it.npc = PC_W'({$urandom, $urandom});
		it.terr = 1'($urandom);
		return it;
	endfunction

	function automatic dbg_item_t request_item(logic [1:0] kd, logic w, logic [15:0] a);
		dbg_item_t it;
		it = random_item(MODE_REQ);
		it.kind = kd;
		it.wr = w;
		it.addr = a;
		return it;
	endfunction

	// only entries filled by a call since reset may be read back
	function automatic logic [15:0] trace_entry_addr();
		int filled [$];
		int s;
		for (int i = 0; i < SLOTS; i++)
			if (sb.frame_written[i]) filled.push_back(i);
		if (filled.size() == 0) return ADDR_COUNT;
		s = filled[$urandom_range(0, filled.size() - 1)];
		return {REGION_DBG, IDX_TRACE + 12'(2 * s + $urandom_range(0, 1))};
	endfunction

	function automatic dbg_item_t next_random_item();
		int r;
		int pick;
		int region;
		logic [11:0] idx;
		r = $urandom_range(0, 99);
		if (sb.waiting_on != PEND_NONE) begin
			if (r < 45) return random_item(MODE_DONE);
			if (r < 50) return random_item(MODE_REQ);
			return random_item((r < 76) ? MODE_CALL : MODE_RET);
		end
		if (r < 30) return random_item(MODE_CALL);
		if (r < 55) return random_item(MODE_RET);
		if (r < 58) return random_item(MODE_DONE);
		pick = $urandom_range(0, 99);
		if (pick < 12) return request_item(REQ_PROG, 1'($urandom), 16'($urandom));
		if (pick < 24) return request_item(2'($urandom_range(2, 3)), 1'($urandom), 16'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 25) return request_item(REQ_REGACC, 1'($urandom), {REGION_CSR, 12'($urandom)});
		if (pick < 50) return request_item(REQ_REGACC, 1'($urandom), {REGION_REG, 12'($urandom)});
		if (pick < 62) return request_item(REQ_REGACC, 1'($urandom), ADDR_COUNT);
		if (pick < 80) return request_item(REQ_REGACC, 1'($urandom), trace_entry_addr());
		if (pick < 88) begin
			// debug region indexes with no function
			case ($urandom_range(0, 2))
				0: idx = 12'($urandom_range(0, 63));
				1: idx = 12'($urandom_range(65, 127));
				default: idx = 12'($urandom_range(192, 4095));
			endcase
			return request_item(REQ_REGACC, 1'($urandom), {REGION_DBG, idx});
		end
		region = $urandom_range(2, 15);
		if (region == int'(REGION_DBG)) region = 15;
		return request_item(REQ_REGACC, 1'($urandom), {4'(region), 12'($urandom)});
	endfunction

	task automatic push_item(dbg_item_t it);
		in_valid <= 1'b1;
		mode <= it.mode;
		req_kind <= it.kind;
		is_write <= it.wr;
		req_addr <= it.addr;
		data_in <= it.data;
		call_pc <= it.pc;
		call_next_pc <= it.npc;
		target_error <= it.terr;
		do @(posedge clk); while (!in_ready);
		sb.note_request(it);
	endtask

	task automatic idle_for(int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{result_kind, fwd_write, fwd_addr, data_out, rsp_err});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else if (arst_n) quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("debug_access_dispatch_with_call_trace_core regression: fail");
			$finish;
		end
	end

	// receiver: stall patterns of random length, plus one long hold on request
	initial begin
		int style;
		int span;
		out_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_active = 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				hold_active = 1'b0;
			end else begin
				style = $urandom_range(0, 3);
				span = $urandom_range(10, 100);
				for (int c = 0; c < span && !hold_req; c++) begin
					case (style)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= ($urandom_range(0, 7) == 0);
						default: out_ready <= ~out_ready;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		dbg_item_t d;
		int accepted;
		int burst_left;
		bit held;
		bit drained;
		bit ignored;
		quiet_cycles = 0;
		hold_req = 1'b0;
		hold_active = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_CALL;
		req_kind = REQ_REGACC;
		is_write = 1'b0;
		req_addr = '0;
		data_in = '0;
		call_pc = '0;
		call_next_pc = '0;
		target_error = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// return on an empty trace, then the count of an empty trace
		push_item(random_item(MODE_RET));
		push_item(request_item(REQ_REGACC, 1'b0, ADDR_COUNT));
		d = random_item(MODE_CALL);
		d.pc = '0;
		d.npc = '0;
		push_item(d);
		d.pc = '1;
		d.npc = '1;
		push_item(d);
		for (int s = 0; s < 4; s++)
			push_item(request_item(REQ_REGACC, 1'(s >> 1), {REGION_DBG, IDX_TRACE + 12'(s)}));
		// count loaded to one below full, then a call fills it and the next is dropped
		d = request_item(REQ_REGACC, 1'b1, ADDR_COUNT);
		d.data = 64'hFFFF_FFFF_FFFF_FFFE;
		push_item(d);
		push_item(random_item(MODE_CALL));
		push_item(random_item(MODE_CALL));
		push_item(request_item(REQ_REGACC, 1'b0, ADDR_COUNT));
		push_item(request_item(REQ_REGACC, 1'b0, {REGION_DBG, IDX_TRACE + 12'(2 * (SLOTS - 2))}));
		push_item(request_item(REQ_REGACC, 1'b0,
			{REGION_DBG, IDX_TRACE + 12'(2 * (SLOTS - 2) + 1)}));
		push_item(random_item(MODE_RET));
		// csr access, a request while it is pending, and a completion with error set
		d = request_item(REQ_REGACC, 1'b0, {REGION_CSR, 12'hFFF});
		d.data = '1;
		push_item(d);
		push_item(request_item(REQ_PROG, 1'b0, '0));
		d = random_item(MODE_DONE);
		d.terr = 1'b1;
		push_item(d);
		push_item(request_item(REQ_REGACC, 1'b1, {REGION_REG, 12'hFFF}));
		push_item(random_item(MODE_DONE));
		push_item(request_item(REQ_PROG, 1'b1, 16'hFFFF));
		push_item(d);
		push_item(request_item(REQ_RSVD_2, 1'b0, {REGION_CSR, 12'h000}));
		push_item(request_item(REQ_RSVD_3, 1'b1, ADDR_COUNT));
		push_item(random_item(MODE_DONE));
		push_item(request_item(REQ_REGACC, 1'b1, {REGION_DBG, 12'hFFF}));
		push_item(request_item(REQ_REGACC, 1'b0, 16'hF123));
		d = request_item(REQ_REGACC, 1'b1, ADDR_COUNT);
		d.data = 64'hFFFF_FFFF_FFFF_FFE0;
		push_item(d);

		accepted = 0;
		burst_left = 0;
		held = 1'b0;
		drained = 1'b0;
		while (accepted < ITEM_GOAL) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 15));
			end
			if (accepted == ITEM_GOAL / 3 && !held) begin
				// hold the output long enough for the core to back up into its input
				held = 1'b1;
				hold_req = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (!hold_active);
				for (int k = 0; k < 40; k++) begin
					if (sb.waiting_on != PEND_NONE) push_item(random_item(MODE_DONE));
					else if (k % 2 == 1)
						push_item(request_item(2'($urandom_range(2, 3)), 1'($urandom),
							16'($urandom)));
					else push_item(request_item(REQ_REGACC, 1'b0, ADDR_COUNT));
				end
			end
			if (accepted == 2 * ITEM_GOAL / 3 && !drained) begin
				drained = 1'b1;
				settle();
			end
			d = next_random_item();
			ignored = (d.mode == MODE_REQ && sb.waiting_on != PEND_NONE) ||
				(d.mode == MODE_DONE && sb.waiting_on == PEND_NONE);
			push_item(d);
			if (!ignored) accepted++;
			burst_left--;
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("debug_access_dispatch_with_call_trace_core regression: pass");
		end else begin
			$display("debug_access_dispatch_with_call_trace_core regression: fail");
		end
		$finish;
	end

endmodule
